// File: hw/rtl/gmp_pkg.sv
// Shared types and constants for the grid minimum path cost block.
// Used by the register file, the cell cost logic and the top level.
package gmp_pkg;

   localparam int CFG_DIM_W  = 11;   // grid_cols / grid_rows register width
   localparam int START_W    = 4;    // start_cost register width
   localparam int PCOST_W    = 12;   // path_cost result width
   localparam int ROW_W      = 10;   // row counter width
   localparam int MAX_ROWS   = 1024;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   // register index, taken from paddr[3:2]
   localparam logic [1:0] REG_GRID_COLS  = 2'd0;
   localparam logic [1:0] REG_GRID_ROWS  = 2'd1;
   localparam logic [1:0] REG_START_COST = 2'd2;

   localparam logic [CFG_DIM_W-1:0] GRID_COLS_RST  = 11'd1024;
   localparam logic [CFG_DIM_W-1:0] GRID_ROWS_RST  = 11'd1024;
   localparam logic [START_W-1:0]   START_COST_RST = 4'd2;

   typedef struct packed {
      logic [CFG_DIM_W-1:0] grid_cols;
      logic [CFG_DIM_W-1:0] grid_rows;
      logic [START_W-1:0]   start_cost;
      logic                 restart;     // size written: next item is top-left
   } cfg_type;

endpackage

// File: hw/rtl/grid_min_path_dp.sv
// Grid minimum path cost: one cell per item, row-major, costs via right/down/diagonal steps.
// Pipeline: 2 register stages (s1, rsp); rsp_tvalid rises once the s1 item advances, which rsp_tready can stall.
// Throughput: one item per cycle unless rsp_tready stalls; the line buffer read port and a left register feed it.
// Reset: counters, neighbor registers and handshake state clear; registers take
// 1024 x 1024 grid and start cost 2. The line buffer needs no clearing.
module grid_min_path_dp
   import gmp_pkg::*;
#(
   parameter int MAX_COLS  = 1024,
   parameter int COST_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [0] open_cell, [7:1] zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] reachable, [12:1] path_cost, [15:13] zero
   output logic                  rsp_tlast,   // last_cell
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int IdxW  = $clog2(MAX_COLS);
   localparam int ColW  = $clog2(MAX_COLS + 1);
   localparam int WordW = COST_BITS + 1;

   cfg_type cfg;

   logic [ColW-1:0]      cols_eff;
   logic [ROW_W:0]       rows_eff;
   logic [IdxW-1:0]      col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [IdxW-1:0]      c_cur;
   logic [ROW_W-1:0]     r_cur;
   logic [ColW-1:0]      c_inc;
   logic [ROW_W:0]       r_inc;
   logic                 cur_last;

   logic                 accept;
   logic                 advance;

   logic                 s1_valid_ff;
   logic                 s1_open_ff;
   logic [IdxW-1:0]      s1_col_ff;
   logic                 s1_first_row_ff;
   logic                 s1_first_col_ff;
   logic                 s1_last_ff;
   logic                 byp_ff;
   logic [WordW-1:0]     byp_data_ff;

   logic [WordW-1:0]     left_ff;
   logic [WordW-1:0]     upleft_ff;
   logic [WordW-1:0]     rd_data;
   logic [WordW-1:0]     up;
   logic [WordW-1:0]     cost_word;

   logic                 rsp_valid_ff;
   logic                 rsp_reach_ff;
   logic [PCOST_W-1:0]   rsp_cost_ff;
   logic                 rsp_last_ff;

   gmp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // zero size acts as one, oversize clamps
   always_comb begin
      if (cfg.grid_cols == '0) begin
         cols_eff = ColW'(1);
      end else if (32'(cfg.grid_cols) > MAX_COLS) begin
         cols_eff = ColW'(MAX_COLS);
      end else begin
         cols_eff = ColW'(cfg.grid_cols);
      end
      if (cfg.grid_rows == '0) begin
         rows_eff = (ROW_W+1)'(1);
      end else if (32'(cfg.grid_rows) > MAX_ROWS) begin
         rows_eff = (ROW_W+1)'(MAX_ROWS);
      end else begin
         rows_eff = (ROW_W+1)'(cfg.grid_rows);
      end
   end

   assign c_cur    = (ColW'(col_ff) >= cols_eff) ? '0 : col_ff;
   assign r_cur    = ((ROW_W+1)'(row_ff) >= rows_eff) ? '0 : row_ff;
   assign c_inc    = ColW'(c_cur) + 1'b1;
   assign r_inc    = (ROW_W+1)'(r_cur) + 1'b1;
   assign cur_last = (r_inc == rows_eff) && (c_inc == cols_eff);

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg.restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (c_inc >= cols_eff) begin
            col_in = '0;
            row_in = (r_inc >= rows_eff) ? '0 : r_inc[ROW_W-1:0];
         end else begin
            col_in = c_inc[IdxW-1:0];
            row_in = r_cur;
         end
      end
   end

   gmp_linebuf #(
      .DEPTH (MAX_COLS),
      .WIDTH (WordW)
   ) u_linebuf (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (s1_col_ff),
      .wr_data (cost_word),
      .rd_en   (accept),
      .rd_addr (c_cur),
      .rd_data (rd_data)
   );

   // same column written by the item leaving while this one is read
   always_comb begin
      if (s1_first_row_ff) begin
         up = '0;
      end else if (byp_ff) begin
         up = byp_data_ff;
      end else begin
         up = rd_data;
      end
   end

   gmp_cell #(
      .COST_BITS (COST_BITS)
   ) u_cell (
      .open_cell  (s1_open_ff),
      .first_row  (s1_first_row_ff),
      .first_col  (s1_first_col_ff),
      .start_cost (cfg.start_cost),
      .up         (up),
      .upleft     (upleft_ff),
      .left       (left_ff),
      .cost       (cost_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         left_ff      <= '0;
         upleft_ff    <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            left_ff      <= cost_word;
            upleft_ff    <= up;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_open_ff      <= req_tdata[0];
         s1_col_ff       <= c_cur;
         s1_first_row_ff <= (r_cur == '0);
         s1_first_col_ff <= (c_cur == '0);
         s1_last_ff      <= cur_last;
         byp_ff          <= s1_valid_ff && (s1_col_ff == c_cur);
         byp_data_ff     <= cost_word;
      end
      if (advance) begin
         rsp_reach_ff <= !cost_word[COST_BITS];
         rsp_cost_ff  <= cost_word[COST_BITS] ? '0 : PCOST_W'(cost_word[COST_BITS-1:0]);
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-PCOST_W-1){1'b0}}, rsp_cost_ff, rsp_reach_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_unreach_zero_cost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_reach_ff |-> rsp_cost_ff == '0)
      else $error("unreachable cell with nonzero cost");

   a_wall_unreach: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_open_ff |-> cost_word[COST_BITS])
      else $error("wall cell computed as reachable");

   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      accept && cur_last |=> col_ff == '0 && row_ff == '0)
      else $error("grid did not restart after last cell");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_col_ff))
      else $error("held cell lost from compute stage");

endmodule

// File: hw/rtl/gmp_csr.sv
// Configuration registers behind an APB-style port.
// Depends on gmp_pkg for register indexes, widths and the config struct.
module gmp_csr
   import gmp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [CFG_DIM_W-1:0] cols_ff, cols_in;
   logic [CFG_DIM_W-1:0] rows_ff, rows_in;
   logic [START_W-1:0]   start_ff, start_in;
   logic                 restart;
   logic                 wr_en;
   logic [1:0]           reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[3:2];

   always_comb begin
      cols_in  = cols_ff;
      rows_in  = rows_ff;
      start_in = start_ff;
      restart  = 1'b0;
      if (wr_en) begin
         unique case (reg_idx)
            REG_GRID_COLS: begin
               cols_in = csr_pwdata[CFG_DIM_W-1:0];
               restart = 1'b1;
            end
            REG_GRID_ROWS: begin
               rows_in = csr_pwdata[CFG_DIM_W-1:0];
               restart = 1'b1;
            end
            REG_START_COST: begin
               start_in = csr_pwdata[START_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_GRID_COLS:  csr_prdata = CSR_DATA_W'(cols_ff);
         REG_GRID_ROWS:  csr_prdata = CSR_DATA_W'(rows_ff);
         REG_START_COST: csr_prdata = CSR_DATA_W'(start_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff  <= GRID_COLS_RST;
         rows_ff  <= GRID_ROWS_RST;
         start_ff <= START_COST_RST;
      end else begin
         cols_ff  <= cols_in;
         rows_ff  <= rows_in;
         start_ff <= start_in;
      end
   end

   assign cfg.grid_cols  = cols_ff;
   assign cfg.grid_rows  = rows_ff;
   assign cfg.start_cost = start_ff;
   assign cfg.restart    = restart;

endmodule

// File: hw/rtl/gmp_linebuf.sv
// Line buffer holding the cost words of the row above.
// One write and one registered read per cycle; no package dependency.
module gmp_linebuf #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 13
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds while no new item enters
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/gmp_cell.sv
// Cost of one grid cell from its up, up-left and left neighbors.
// Depends on gmp_pkg for the start cost width.
module gmp_cell
   import gmp_pkg::*;
#(
   parameter int COST_BITS = 12
) (
   input  logic                 open_cell,
   input  logic                 first_row,
   input  logic                 first_col,
   input  logic [START_W-1:0]   start_cost,
   input  logic [COST_BITS:0]   up,
   input  logic [COST_BITS:0]   upleft,
   input  logic [COST_BITS:0]   left,
   output logic [COST_BITS:0]   cost
);

   localparam logic [COST_BITS:0] UNREACH  = {1'b1, {COST_BITS{1'b0}}};
   localparam logic [COST_BITS:0] COST_MAX = {1'b0, {COST_BITS{1'b1}}};

   logic [COST_BITS:0] min_ul;
   logic [COST_BITS:0] best;
   logic [COST_BITS:0] stepped;

   // unreachable words sit above every cost, so a plain compare works
   assign min_ul = (up < upleft) ? up : upleft;

   always_comb begin
      if (first_row) begin
         best = left;
      end else if (first_col) begin
         best = up;
      end else begin
         best = (min_ul < left) ? min_ul : left;
      end
   end

   always_comb begin
      if (best[COST_BITS]) begin
         stepped = UNREACH;
      end else if (best == COST_MAX) begin
         stepped = COST_MAX;
      end else begin
         stepped = best + 1'b1;
      end
   end

   always_comb begin
      if (!open_cell) begin
         cost = UNREACH;
      end else if (first_row && first_col) begin
         cost = (COST_BITS+1)'(start_cost);
      end else begin
         cost = stepped;
      end
   end

endmodule

// File: verif/tb_grid_min_path_dp.sv
`timescale 1ns / 1ps
// Self-checking testbench for grid_min_path_dp: streams open/wall cells in on req_,
// predicts every path cost in a scoreboard and checks each rsp_ item in order.
// Depends on gmp_pkg and the grid_min_path_dp RTL only.
module tb_grid_min_path_dp;
   import gmp_pkg::*;

   localparam int                GRID_MAX_COLS = 1024;
   localparam int                WORD_W        = PCOST_W + 1;
   localparam logic [WORD_W-1:0] UNREACH_MARK  = {1'b1, {PCOST_W{1'b0}}};
   localparam logic [WORD_W-1:0] COST_CEIL     = {1'b0, {PCOST_W{1'b1}}};
   localparam logic [1:0]        REG_UNUSED    = 2'd3;
   localparam int                HOLD_CYCLES   = 300;
   localparam int                RANDOM_CELLS  = 1850;

   typedef struct packed {
      logic               reachable;
      logic [PCOST_W-1:0] cost;
      logic               last;
   } cell_result_type;

   class path_cost_board_type;
      logic [WORD_W-1:0]    row_above [GRID_MAX_COLS];
      logic [WORD_W-1:0]    left_word;
      logic [WORD_W-1:0]    upleft_word;
      int unsigned          col_pos;
      int unsigned          row_pos;
      logic [CFG_DIM_W-1:0] cols_reg;
      logic [CFG_DIM_W-1:0] rows_reg;
      logic [START_W-1:0]   start_reg;
      cell_result_type      costs_due[$];
      int unsigned          mismatch_count;
      int unsigned          results_checked;
      int unsigned          grids_closed;

      function new();
         foreach (row_above[i]) row_above[i] = '0;
         left_word       = '0;
         upleft_word     = '0;
         col_pos         = 0;
         row_pos         = 0;
         cols_reg        = GRID_COLS_RST;
         rows_reg        = GRID_ROWS_RST;
         start_reg       = START_COST_RST;
         mismatch_count  = 0;
         results_checked = 0;
         grids_closed    = 0;
      endfunction

      function void report(string msg);
         mismatch_count++;
         if (mismatch_count <= 10) $display("MISMATCH: %s", msg);
      endfunction

      // 0 acts as 1, oversize clamps to the top
      function int unsigned clamp_dim(logic [CFG_DIM_W-1:0] v, int unsigned top);
         if (v == 0) return 1;
         if (v > top) return top;
         return v;
      endfunction

      function logic [WORD_W-1:0] step_cost(logic [WORD_W-1:0] w);
         if (w[PCOST_W]) return UNREACH_MARK;
         if (w >= COST_CEIL) return COST_CEIL;
         return w + 1'b1;
      endfunction

      function void write_reg(logic [1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_GRID_COLS: begin
               cols_reg = value[CFG_DIM_W-1:0];
               col_pos  = 0;
               row_pos  = 0;
            end
            REG_GRID_ROWS: begin
               rows_reg = value[CFG_DIM_W-1:0];
               col_pos  = 0;
               row_pos  = 0;
            end
            REG_START_COST: start_reg = value[START_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [CSR_DATA_W-1:0] reg_value(logic [1:0] idx);
         case (idx)
            REG_GRID_COLS:  return CSR_DATA_W'(cols_reg);
            REG_GRID_ROWS:  return CSR_DATA_W'(rows_reg);
            REG_START_COST: return CSR_DATA_W'(start_reg);
            default:        return '0;
         endcase
      endfunction

      // accepted cell: work out its cost word and queue the expected item
      function void note_cell(logic is_open);
         int unsigned       cols;
         int unsigned       rows;
         int unsigned       c;
         int unsigned       r;
         logic [WORD_W-1:0] up;
         logic [WORD_W-1:0] best;
         logic [WORD_W-1:0] word;
         cell_result_type   due;
         cols = clamp_dim(cols_reg, GRID_MAX_COLS);
         rows = clamp_dim(rows_reg, MAX_ROWS);
         c    = (col_pos >= cols) ? 0 : col_pos;
         r    = (row_pos >= rows) ? 0 : row_pos;
         up   = (r > 0) ? row_above[c] : '0;
         // unreachable mark sits above the cost bits, so it always loses the min
         best = (up < upleft_word) ? up : upleft_word;
         if (left_word < best) best = left_word;
         word = '0;
         if (!is_open) word = UNREACH_MARK;
         else if (r == 0 && c == 0) word[START_W-1:0] = start_reg;
         else if (r == 0) word = step_cost(left_word);
         else if (c == 0) word = step_cost(up);
         else word = step_cost(best);
         upleft_word  = up;
         left_word    = word;
         row_above[c] = word;
         due.last = (r == rows - 1) && (c == cols - 1);
         if (c + 1 >= cols) begin
            col_pos = 0;
            row_pos = (r + 1 >= rows) ? 0 : r + 1;
         end else begin
            col_pos = c + 1;
            row_pos = r;
         end
         due.reachable = !word[PCOST_W];
         due.cost      = word[PCOST_W] ? '0 : word[PCOST_W-1:0];
         costs_due     = {costs_due, due};
      endfunction

      function void check_cell(logic reachable, logic [PCOST_W-1:0] cost, logic last);
         cell_result_type due;
         if (costs_due.size() == 0) begin
            report($sformatf("item with nothing pending: reachable=%0b cost=%0d last=%0b",
                             reachable, cost, last));
            return;
         end
         due = costs_due.pop_front();
         results_checked++;
         if (due.reachable !== reachable || due.cost !== cost || due.last !== last)
            report($sformatf({"item %0d: expected reachable=%0b cost=%0d last=%0b,",
                              " got %0b/%0d/%0b"},
                             results_checked, due.reachable, due.cost, due.last,
                             reachable, cost, last));
         else if (last)
            grids_closed++;
      endfunction
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;   // [0] open_cell, [7:1] zero
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // [0] reachable, [12:1] path_cost, [15:13] zero
   logic                  rsp_tlast;          // last_cell
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   path_cost_board_type board = new();
   bit             no_idle      = 1'b0;
   bit             hold_request = 1'b0;
   int unsigned    cells_sent   = 0;
   int unsigned    reg_reads    = 0;

   always #5 clock = ~clock;

   grid_min_path_dp u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (no_idle || roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [CFG_DIM_W-1:0] pick_dim();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 8) return '0;
      if (roll < 70) return CFG_DIM_W'($urandom_range(1, 6));
      if (roll < 92) return CFG_DIM_W'($urandom_range(7, 20));
      return CFG_DIM_W'($urandom_range(21, 64));
   endfunction

   // all tasks below start and end just after a rising edge
   task automatic csr_write(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.write_reg(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(input logic [1:0] idx, output logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      value = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_regs();
      logic [CSR_DATA_W-1:0] value;
      logic [1:0]            idx;
      for (int i = 0; i < 3; i++) begin
         idx = 2'(i);
         csr_read(idx, value);
         reg_reads++;
         if (value !== board.reg_value(idx))
            board.report($sformatf("register %0d read %0h, expected %0h",
                                   idx, value, board.reg_value(idx)));
      end
   endtask

   task automatic send_cell(input logic is_open);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-1){1'b0}}, is_open};
      do @(posedge clock); while (!req_tready);
      board.note_cell(is_open);
      cells_sent++;
   endtask

   // bit 0 goes first
   task automatic send_bits(input logic [31:0] bits, input int unsigned count);
      for (int i = 0; i < count; i++) send_cell(bits[i]);
   endtask

   // block is idle once every result is in and the pipeline has had time to empty
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.costs_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_dims(input logic [CFG_DIM_W-1:0] cols, input logic [CFG_DIM_W-1:0] rows);
      if ($urandom_range(1)) begin
         csr_write(REG_GRID_COLS, CSR_DATA_W'(cols));
         csr_write(REG_GRID_ROWS, CSR_DATA_W'(rows));
      end else begin
         csr_write(REG_GRID_ROWS, CSR_DATA_W'(rows));
         csr_write(REG_GRID_COLS, CSR_DATA_W'(cols));
      end
   endtask

   task automatic run_cells(input int unsigned count, input int unsigned open_pm,
                            input bit squeeze);
      if ($urandom_range(1)) csr_write(REG_START_COST, CSR_DATA_W'($urandom_range(15)));
      read_regs();
      no_idle = squeeze || ($urandom_range(3) == 0);
      if (squeeze) hold_request = 1'b1;
      repeat (count) send_cell($urandom_range(999) < open_pm);
      drain();
      no_idle = 1'b0;
   endtask

   // result side: random stalls plus the long hold asked for by the stimulus
   initial begin : result_sink
      int unsigned stall_left;
      int unsigned hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            board.check_cell(rsp_tdata[0], rsp_tdata[PCOST_W:1], rsp_tlast);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            stall_left = pick_gap();
            if (stall_left > 0) begin
               stall_left--;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned          random_cells;
      int unsigned          phases;
      int unsigned          area;
      int unsigned          count;
      int unsigned          open_pm;
      logic [CFG_DIM_W-1:0] cols;
      logic [CFG_DIM_W-1:0] rows;
      random_cells = 0;
      phases       = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: 1024 x 1024 grid, start cost 2
      read_regs();
      send_bits(32'b1011, 4);
      drain();
      // 3x3 grid, best path through the diagonal, then the start of the next grid
      csr_write(REG_START_COST, 32'd15);
      csr_write(REG_GRID_COLS, 32'd3);
      csr_write(REG_GRID_ROWS, 32'd3);
      read_regs();
      send_bits(32'b1_101_110_011, 10);
      drain();
      // zero sizes act as a 1x1 grid: every item is both start and last
      csr_write(REG_START_COST, 32'd0);
      csr_write(REG_GRID_COLS, 32'd0);
      csr_write(REG_GRID_ROWS, 32'd0);
      send_bits(32'b01, 2);
      drain();
      csr_write(REG_UNUSED, 32'hFFFF_FFFF);
      read_regs();
      send_bits(32'b1, 1);
      drain();
      // start cost written mid-grid must not restart the grid
      csr_write(REG_GRID_COLS, 32'd2);
      csr_write(REG_GRID_ROWS, 32'd2);
      send_bits(32'b11, 2);
      drain();
      csr_write(REG_START_COST, 32'd7);
      send_bits(32'b111, 3);
      drain();

      while (random_cells < RANDOM_CELLS) begin
         if (phases == 1) begin
            // receiver holds off while cells keep coming, so the block backs up
            set_dims(11'd5, 11'd7);
            count = 120;
            run_cells(count, 900, 1'b1);
         end else if (phases == 3) begin
            // widest row, single row grid, plus a few cells into the next grid
            set_dims($urandom_range(1) ? 11'd1024 : 11'd2047, 11'd1);
            count = 1027;
            run_cells(count, 998, 1'b0);
         end else begin
            cols = pick_dim();
            rows = pick_dim();
            area = (cols == 0 ? 1 : cols) * (rows == 0 ? 1 : rows);
            if (area <= 60) count = area * $urandom_range(1, 3) + $urandom_range(0, area);
            else count = $urandom_range(40, 150);
            case ($urandom_range(3))
               0:       open_pm = 500;
               1:       open_pm = 800;
               2:       open_pm = 950;
               default: open_pm = 1000;
            endcase
            // now and then keep the size so the grid carries on across the pause
            if ($urandom_range(4) != 0) set_dims(cols, rows);
            run_cells(count, open_pm, 1'b0);
         end
         random_cells += count;
         phases++;
      end

      drain();
      repeat (10) @(posedge clock);
      if (board.costs_due.size() != 0)
         board.report($sformatf("%0d results never arrived", board.costs_due.size()));
      $display("Sent %0d cells over %0d random phases after the directed opening;",
               cells_sent, phases);
      $display("%0d grids ended on their corner, %0d items and %0d register reads checked.",
               board.grids_closed, board.results_checked, reg_reads);
      $display("%0d mismatches.", board.mismatch_count);
      if (board.mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/gmp_pkg.sv
hw/rtl/gmp_csr.sv
hw/rtl/gmp_linebuf.sv
hw/rtl/gmp_cell.sv
hw/rtl/grid_min_path_dp.sv
verif/tb_grid_min_path_dp.sv
